### hw/rtl/qeb_pkg.sv
// ----------------------------------------------------------------------------
// qeb_pkg: shared types and constants for the quadrature encoder bank
// Encoder count, field widths, transition marks and the command word that
// travels from the front classifier to the back counter stage.
// ----------------------------------------------------------------------------
`default_nettype none

package qeb_pkg;

	// Number of encoders in the bank (1..8)
	localparam int NUM_ENCODERS = 4;

	// Field widths
	localparam int CODE_W    = 16;
	localparam int BUTTON_W  = 8;
	localparam int IDX_W     = 3;
	localparam int COUNT_W   = 8;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;

	// Index width into the per-encoder count arrays
	localparam int ENC_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

	// Saturation limits of both counts
	localparam logic signed [COUNT_W-1:0] COUNT_MIN = -8'sd64;
	localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd64;

	// Last encoder index
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENCODERS - 1);

	// Command queue depth
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// Operation codes carried on tuser
	typedef enum logic {
		OP_POLL  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	// Last counting transition of an encoder
	typedef enum logic [2:0] {
		MARK_NONE       = 3'd0,
		MARK_DOWN_FROM1 = 3'd1,
		MARK_DOWN_FROM0 = 3'd2,
		MARK_UP_FROM3   = 3'd3,
		MARK_UP_FROM1   = 3'd4
	} mark_t;

	// Classified command: clear, or per-encoder step direction and target
	typedef struct packed {
		logic                    clear;
		logic [NUM_ENCODERS-1:0] step_dn;
		logic [NUM_ENCODERS-1:0] step_up;
		logic [NUM_ENCODERS-1:0] held;
	} cmd_t;

endpackage

`default_nettype wire

### hw/rtl/qeb_front.sv
// ----------------------------------------------------------------------------
// qeb_front: transition classifier
// Takes poll and clear transactions, compares codes against the previous
// poll, applies the anti-repeat marks and emits one command per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module qeb_front import qeb_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,        // transaction accepted
	input  wire logic                op,
	input  wire logic [CODE_W-1:0]   code_bits,
	input  wire logic [BUTTON_W-1:0] button_held,
	output cmd_t                     cmd
);

	logic [CODE_W-1:0] prev_codes_q;
	mark_t             mark_q [NUM_ENCODERS];
	mark_t             mark_d [NUM_ENCODERS];
	logic              is_clear;

	assign is_clear = (op == OP_CLEAR);

	// Classify each encoder's transition
	always_comb begin
		logic [1:0] now_c;
		logic [1:0] was_c;
		cmd.clear   = is_clear;
		cmd.step_dn = '0;
		cmd.step_up = '0;
		cmd.held    = '0;
		for (int k = 0; k < NUM_ENCODERS; k++) begin
			now_c          = code_bits[2*k +: 2];
			was_c          = prev_codes_q[2*k +: 2];
			mark_d[k]      = mark_q[k];
			cmd.held[k]    = button_held[k];
			if ((now_c == 2'd0 && was_c == 2'd1 && mark_q[k] != MARK_DOWN_FROM1) ||
			    (now_c == 2'd3 && was_c == 2'd0 && mark_q[k] != MARK_DOWN_FROM0)) begin
				cmd.step_dn[k] = !is_clear;
				mark_d[k]      = (was_c == 2'd1) ? MARK_DOWN_FROM1 : MARK_DOWN_FROM0;
			end else if ((now_c == 2'd0 && was_c == 2'd3 && mark_q[k] != MARK_UP_FROM3) ||
			             (now_c == 2'd3 && was_c == 2'd1 && mark_q[k] != MARK_UP_FROM1)) begin
				cmd.step_up[k] = !is_clear;
				mark_d[k]      = (was_c == 2'd1) ? MARK_UP_FROM1 : MARK_UP_FROM3;
			end
		end
	end

	// Update codes and marks on a poll; hold them on a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_codes_q <= '0;
			for (int k = 0; k < NUM_ENCODERS; k++) begin
				mark_q[k] <= MARK_NONE;
			end
		end else if (take && !is_clear) begin
			prev_codes_q <= code_bits;
			for (int k = 0; k < NUM_ENCODERS; k++) begin
				mark_q[k] <= mark_d[k];
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/qeb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// qeb_cmd_fifo: command queue
// Short register queue between the classifier and the counter stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qeb_cmd_fifo import qeb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output cmd_t      pop_cmd
);

	cmd_t              mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == FCNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/qeb_back.sv
// ----------------------------------------------------------------------------
// qeb_back: counter stage and result serializer
// Applies saturating steps or a clear to the counts, then, for a poll, sends one
// result per encoder through a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module qeb_back import qeb_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	input  wire cmd_t                cmd,
	output logic                     cmd_pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [IDX_W-1:0]         encoder_index,
	output logic signed [COUNT_W-1:0] turn_count,
	output logic signed [COUNT_W-1:0] held_turn_count,
	output logic                     last
);

	logic signed [COUNT_W-1:0] plain_q [NUM_ENCODERS];
	logic signed [COUNT_W-1:0] held_q  [NUM_ENCODERS];
	logic                      busy_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      advance;
	logic                      idx_last;

	assign advance  = !out_valid || out_ready;
	assign idx_last = (idx_q == LAST_IDX);
	assign cmd_pop  = cmd_valid && (!busy_q || (advance && idx_last));

	// Apply steps or clear when a command is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_ENCODERS; k++) begin
				plain_q[k] <= '0;
				held_q[k]  <= '0;
			end
		end else if (cmd_pop) begin
			for (int k = 0; k < NUM_ENCODERS; k++) begin
				if (cmd.clear) begin
					plain_q[k] <= '0;
					held_q[k]  <= '0;
				end else if (cmd.held[k]) begin
					if (cmd.step_dn[k] && held_q[k] > COUNT_MIN) begin
						held_q[k] <= held_q[k] - 8'sd1;
					end else if (cmd.step_up[k] && held_q[k] < COUNT_MAX) begin
						held_q[k] <= held_q[k] + 8'sd1;
					end
				end else begin
					if (cmd.step_dn[k] && plain_q[k] > COUNT_MIN) begin
						plain_q[k] <= plain_q[k] - 8'sd1;
					end else if (cmd.step_up[k] && plain_q[k] < COUNT_MAX) begin
						plain_q[k] <= plain_q[k] + 8'sd1;
					end
				end
			end
		end
	end

	// Walk encoder index while a poll is being reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (cmd_pop) begin
			busy_q <= !cmd.clear;
			idx_q  <= '0;
		end else if (busy_q && advance) begin
			if (idx_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= busy_q;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (busy_q && advance) begin
			encoder_index   <= idx_q;
			turn_count      <= plain_q[idx_q[ENC_W-1:0]];
			held_turn_count <= held_q[idx_q[ENC_W-1:0]];
			last            <= idx_last;
		end
	end

`ifndef ASSERT_OFF
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> encoder_index == LAST_IDX)
		else $error("last flag on wrong encoder index");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> turn_count >= COUNT_MIN && turn_count <= COUNT_MAX &&
			held_turn_count >= COUNT_MIN && held_turn_count <= COUNT_MAX)
		else $error("count outside saturation range");

	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && cmd.clear |=> !busy_q)
		else $error("clear started a report");

	a_poll_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && !cmd.clear |=> busy_q && idx_q == '0)
		else $error("poll did not start at encoder zero");
`endif

endmodule

`default_nettype wire

### hw/rtl/quadrature_encoder_bank.sv
// A poll accepted into the command queue is popped by the counter stage into its busy
// and index registers; results then leave the output register one per cycle while
// m_tready is high, one per encoder for each poll. The serializer sets the rate.
// A two-entry command queue lets input transactions continue while results drain.
// Reset (arst_n low): counts, previous codes and marks go to zero, queue empties.
// ----------------------------------------------------------------------------
// quadrature_encoder_bank: rotary encoder bank decoder
// Classifies quadrature transitions per encoder and keeps saturating plain
// and held-button turn counts, reported one encoder per result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_encoder_bank import qeb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // [15:0] code_bits, [23:16] button_held
	input  wire logic                 s_tuser,   // [0] op
	// Result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,   // [2:0] encoder_index, [10:3] turn_count,
	                                             // [18:11] held_turn_count, [23:19] zero
	output logic                      m_tlast
);

	cmd_t                      front_cmd;
	cmd_t                      back_cmd;
	logic                      fifo_full;
	logic                      fifo_valid;
	logic                      fifo_pop;
	logic                      take;
	logic [IDX_W-1:0]          encoder_index;
	logic signed [COUNT_W-1:0] turn_count;
	logic signed [COUNT_W-1:0] held_turn_count;

	assign s_tready = !fifo_full;
	assign take     = s_tvalid && s_tready;

	// Classify incoming transactions
	qeb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.op          (s_tuser),
		.code_bits   (s_tdata[CODE_W-1:0]),
		.button_held (s_tdata[CODE_W +: BUTTON_W]),
		.cmd         (front_cmd)
	);

	// Decouple classifier from counter stage
	qeb_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_cmd  (front_cmd),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.not_empty (fifo_valid),
		.pop_cmd   (back_cmd)
	);

	// Count and report
	qeb_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (fifo_valid),
		.cmd             (back_cmd),
		.cmd_pop         (fifo_pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.encoder_index   (encoder_index),
		.turn_count      (turn_count),
		.held_turn_count (held_turn_count),
		.last            (m_tlast)
	);

	// Pack result fields
	assign m_tdata = {5'b0, held_turn_count, turn_count, encoder_index};

endmodule

`default_nettype wire
